// ===== design/packet_script_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef PACKET_SCRIPT_TOKENIZER_MACROS_SVH
`define PACKET_SCRIPT_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define PST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define PST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`else

`define PST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PST_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/pst_pkg.sv =====
// Types, codes and constants of the packet script tokenizer.
`default_nettype none

package pst_pkg;

	localparam int POS_BITS = 16;
	localparam int CHAR_W   = 8;
	localparam int KIND_W   = 4;
	localparam int ERR_W    = 3;
	localparam int OUT_W    = 16;
	localparam int MAX_RES  = 3;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	localparam logic [KIND_W-1:0] K_IDENT  = 4'd0;
	localparam logic [KIND_W-1:0] K_STRING = 4'd1;
	localparam logic [KIND_W-1:0] K_INT    = 4'd2;
	localparam logic [KIND_W-1:0] K_EQUAL  = 4'd3;
	localparam logic [KIND_W-1:0] K_LPAREN = 4'd4;
	localparam logic [KIND_W-1:0] K_RPAREN = 4'd5;
	localparam logic [KIND_W-1:0] K_COMMA  = 4'd6;
	localparam logic [KIND_W-1:0] K_SLASH  = 4'd7;
	localparam logic [KIND_W-1:0] K_COLON  = 4'd8;
	localparam logic [KIND_W-1:0] K_EOF    = 4'd9;

	localparam logic [ERR_W-1:0] E_NONE   = 3'd0;
	localparam logic [ERR_W-1:0] E_UNTERM = 3'd1;
	localparam logic [ERR_W-1:0] E_HEX    = 3'd2;
	localparam logic [ERR_W-1:0] E_CHAR   = 3'd3;
	localparam logic [ERR_W-1:0] E_LONG   = 3'd4;

	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LOW_X  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOW_F  = 8'h66;
	localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;
	localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;

	typedef enum logic [3:0] {
		M_IDLE  = 4'd0,
		M_IDENT = 4'd1,
		M_ZERO  = 4'd2,
		M_DEC   = 4'd3,
		M_HEX0  = 4'd4,
		M_HEX   = 4'd5,
		M_MINUS = 4'd6,
		M_STR   = 4'd7,
		M_ESC   = 4'd8
	} lex_mode_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_in;
		logic              end_of_source;
		logic              no_char;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] token_kind;
		logic [ERR_W-1:0]  error_kind;
		logic [OUT_W-1:0]  start_pos;
		logic [OUT_W-1:0]  token_len;
		logic [CHAR_W-1:0] bad_char;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [1:0]         count;
	} batch_t;

endpackage

`default_nettype wire

// ===== design/pst_ifs.sv =====
// Valid/ready channel interfaces for source bytes and tokens.
`default_nettype none

interface pst_in_if import pst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_in;
	logic              end_of_source;
	logic              no_char;

	modport source(output valid, char_in, end_of_source, no_char, input ready);
	modport sink(input valid, char_in, end_of_source, no_char, output ready);
endinterface

interface pst_out_if import pst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] token_kind;
	logic [ERR_W-1:0]  error_kind;
	logic [OUT_W-1:0]  start_pos;
	logic [OUT_W-1:0]  token_len;
	logic [CHAR_W-1:0] bad_char;
	logic              last_of_run;

	modport source(output valid, token_kind, error_kind, start_pos, token_len, bad_char,
		last_of_run, input ready);
	modport sink(input valid, token_kind, error_kind, start_pos, token_len, bad_char,
		last_of_run, output ready);
endinterface

`default_nettype wire

// ===== design/pst_lexer.sv =====
// Lexer state and the single-pass logic that turns one item into up to three tokens.
`default_nettype none

module pst_lexer import pst_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   commit,
	input  item_t  item,
	output batch_t batch
);

	lex_mode_t           mode_q, mode_v;
	logic [POS_BITS-1:0] pos_q, pos_v;
	logic [POS_BITS-1:0] tstart_q, tstart_v;
	logic                sink_q, sink_v;

	function automatic logic is_num(input logic [CHAR_W-1:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
		return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
	endfunction

	function automatic logic is_hex(input logic [CHAR_W-1:0] c);
		return is_num(c) || (c >= CH_LOW_A && c <= CH_LOW_F) ||
			(c >= CH_UP_A && c <= CH_UP_F);
	endfunction

	function automatic logic is_ident_cont(input logic [CHAR_W-1:0] c);
		return is_alpha(c) || is_num(c) || c == CH_UNDER;
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic logic [KIND_W-1:0] symbol_kind(input logic [CHAR_W-1:0] c);
		logic [KIND_W-1:0] k;
		unique case (c)
			CH_EQUAL:  k = K_EQUAL;
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_COMMA:  k = K_COMMA;
			CH_SLASH:  k = K_SLASH;
			CH_COLON:  k = K_COLON;
			default:   k = K_IDENT;
		endcase
		return k;
	endfunction

	function automatic res_t make_res(input logic [KIND_W-1:0] kind,
		input logic [ERR_W-1:0] err, input logic [POS_BITS-1:0] at,
		input logic [POS_BITS-1:0] len, input logic [CHAR_W-1:0] bad);
		res_t r;
		r.token_kind = kind;
		r.error_kind = err;
		r.start_pos  = OUT_W'(at);
		r.token_len  = OUT_W'(len);
		r.bad_char   = bad;
		return r;
	endfunction

	always_comb begin
		logic [CHAR_W-1:0] c;
		logic              close_f;
		logic              begin_f;
		logic [1:0]        n;
		batch_t            b;

		c       = item.char_in;
		close_f = 1'b0;
		begin_f = 1'b0;
		n       = 2'd0;
		b       = '0;
		mode_v   = mode_q;
		pos_v    = pos_q;
		tstart_v = tstart_q;
		sink_v   = sink_q;

		if (!item.no_char && !sink_q) begin
			if (pos_q == POS_MAX) begin
				b.res[n] = make_res(K_EOF, E_LONG, pos_q, '0, '0);
				n = n + 2'd1;
				sink_v = 1'b1;
				mode_v = M_IDLE;
			end else begin
				unique case (mode_q)
					M_IDENT: begin
						if (!is_ident_cont(c)) begin
							close_f = 1'b1;
						end
					end
					M_ZERO: begin
						if (c == CH_LOW_X || c == CH_UP_X) begin
							mode_v = M_HEX0;
						end else if (is_num(c)) begin
							mode_v = M_DEC;
						end else begin
							close_f = 1'b1;
						end
					end
					M_DEC: begin
						if (!is_num(c)) begin
							close_f = 1'b1;
						end
					end
					M_HEX0: begin
						if (is_hex(c)) begin
							mode_v = M_HEX;
						end else begin
							b.res[n] = make_res(K_EOF, E_HEX, tstart_q, '0, '0);
							n = n + 2'd1;
							sink_v = 1'b1;
							mode_v = M_IDLE;
						end
					end
					M_HEX: begin
						if (!is_hex(c)) begin
							close_f = 1'b1;
						end
					end
					M_MINUS: begin
						if (c == CH_ZERO) begin
							mode_v = M_ZERO;
						end else if (is_num(c)) begin
							mode_v = M_DEC;
						end else begin
							b.res[n] = make_res(K_EOF, E_CHAR, tstart_q, '0, CH_MINUS);
							n = n + 2'd1;
							sink_v = 1'b1;
							mode_v = M_IDLE;
						end
					end
					M_STR: begin
						if (c == CH_QUOTE) begin
							b.res[n] = make_res(K_STRING, E_NONE, tstart_q,
								pos_q + POS_BITS'(1) - tstart_q, '0);
							n = n + 2'd1;
							mode_v = M_IDLE;
						end else if (c == CH_BSLASH) begin
							mode_v = M_ESC;
						end
					end
					M_ESC: begin
						mode_v = M_STR;
					end
					default: begin
						begin_f = 1'b1;
					end
				endcase

				if (close_f) begin
					b.res[n] = make_res((mode_q == M_IDENT) ? K_IDENT : K_INT, E_NONE,
						tstart_q, pos_q - tstart_q, '0);
					n = n + 2'd1;
					begin_f = 1'b1;
				end

				if (begin_f) begin
					mode_v   = M_IDLE;
					tstart_v = pos_q;
					priority if (is_space(c)) begin
						mode_v = M_IDLE;
					end else if (c == CH_MINUS) begin
						mode_v = M_MINUS;
					end else if (c == CH_QUOTE) begin
						mode_v = M_STR;
					end else if (c == CH_ZERO) begin
						mode_v = M_ZERO;
					end else if (is_num(c)) begin
						mode_v = M_DEC;
					end else if (is_alpha(c) || c == CH_UNDER) begin
						mode_v = M_IDENT;
					end else if (symbol_kind(c) != K_IDENT) begin
						b.res[n] = make_res(symbol_kind(c), E_NONE, pos_q, POS_BITS'(1), '0);
						n = n + 2'd1;
					end else begin
						b.res[n] = make_res(K_EOF, E_CHAR, pos_q, '0, c);
						n = n + 2'd1;
						sink_v = 1'b1;
					end
				end

				pos_v = pos_q + POS_BITS'(1);
			end
		end

		if (item.end_of_source) begin
			if (!sink_v) begin
				unique case (mode_v)
					M_IDENT: begin
						b.res[n] = make_res(K_IDENT, E_NONE, tstart_v, pos_v - tstart_v, '0);
						n = n + 2'd1;
					end
					M_ZERO, M_DEC, M_HEX: begin
						b.res[n] = make_res(K_INT, E_NONE, tstart_v, pos_v - tstart_v, '0);
						n = n + 2'd1;
					end
					M_HEX0: begin
						b.res[n] = make_res(K_EOF, E_HEX, tstart_v, '0, '0);
						n = n + 2'd1;
						sink_v = 1'b1;
					end
					M_MINUS: begin
						b.res[n] = make_res(K_EOF, E_CHAR, tstart_v, '0, CH_MINUS);
						n = n + 2'd1;
						sink_v = 1'b1;
					end
					M_STR, M_ESC: begin
						b.res[n] = make_res(K_EOF, E_UNTERM, tstart_v, '0, '0);
						n = n + 2'd1;
						sink_v = 1'b1;
					end
					default: begin
					end
				endcase
				if (!sink_v) begin
					b.res[n] = make_res(K_EOF, E_NONE, pos_v, '0, '0);
					n = n + 2'd1;
				end
			end
			mode_v   = M_IDLE;
			pos_v    = '0;
			tstart_v = '0;
			sink_v   = 1'b0;
		end

		b.count = n;
		batch   = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			tstart_q <= '0;
			sink_q   <= 1'b0;
		end else if (commit) begin
			mode_q   <= mode_v;
			pos_q    <= pos_v;
			tstart_q <= tstart_v;
			sink_q   <= sink_v;
		end
	end

endmodule

`default_nettype wire

// ===== design/pst_result_buf.sv =====
// Result register that holds the tokens of one item and hands them out one beat at a time.
`default_nettype none

module pst_result_buf import pst_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  batch_t batch,
	output logic   free,
	pst_out_if.source tokens
);

	logic               valid_s2;
	res_t [MAX_RES-1:0] res_s2;
	logic [1:0]         cnt_s2;
	logic [1:0]         idx_q;
	logic               last;
	res_t               head;

	assign last = (idx_q == cnt_s2 - 2'd1);
	assign free = !valid_s2 || (tokens.ready && last);
	assign head = res_s2[idx_q];

	assign tokens.valid       = valid_s2;
	assign tokens.token_kind  = head.token_kind;
	assign tokens.error_kind  = head.error_kind;
	assign tokens.start_pos   = head.start_pos;
	assign tokens.token_len   = head.token_len;
	assign tokens.bad_char    = head.bad_char;
	assign tokens.last_of_run = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_s2   <= '0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			cnt_s2   <= batch.count;
			idx_q    <= '0;
		end else if (valid_s2 && tokens.ready) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= batch.res;
		end
	end

endmodule

`default_nettype wire

// ===== design/packet_script_tokenizer.sv =====
// Top level of the packet script tokenizer: input register, lexer and result register.
//
//   channel   direction   beat carries
//   items     in          char_in, end_of_source, no_char
//   tokens    out         token_kind, error_kind, start_pos, token_len, bad_char, last_of_run
//
// An item is taken into the input register and lexed from there; when the lexer commits,
// its tokens land in the result register. One item per cycle is sustained while tokens are
// taken and each item yields at most one token; an item with k tokens holds the result
// register for k output beats, and items with no token pass freely.
// Reset clears the lexer state and both valid flags; no clearing pass is needed.
// A stalled token channel backs up into the input register and then stalls the items channel.
`default_nettype none
`include "packet_script_tokenizer_macros.svh"

module packet_script_tokenizer import pst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pst_in_if.sink    items,
	pst_out_if.source tokens
);

	logic   valid_s1;
	item_t  item_s1;
	batch_t batch;
	logic   buf_free;
	logic   proceed;

	assign proceed     = valid_s1 && (batch.count == 2'd0 || buf_free);
	assign items.ready = !valid_s1 || proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			valid_s1 <= 1'b1;
		end else if (proceed) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.char_in       <= items.char_in;
			item_s1.end_of_source <= items.end_of_source;
			item_s1.no_char       <= items.no_char;
		end
	end

	pst_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (proceed),
		.item   (item_s1),
		.batch  (batch)
	);

	pst_result_buf u_result_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (proceed && batch.count != 2'd0),
		.batch  (batch),
		.free   (buf_free),
		.tokens (tokens)
	);

	`PST_ASSERT_IMP(a_error_is_eof, clk, arst_n, tokens.valid && tokens.error_kind != E_NONE, tokens.token_kind == K_EOF && tokens.token_len == '0)
	`PST_ASSERT_NXT(a_run_continues, clk, arst_n, tokens.valid && tokens.ready && !tokens.last_of_run, tokens.valid)
	`PST_ASSERT_NXT(a_item_held, clk, arst_n, items.valid && items.ready, valid_s1)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the packet script tokenizer: directed and random sources.
`default_nettype none

module tb;
	import pst_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 60;

	typedef struct {
		res_t body;
		logic last;
	} token_t;

	logic clk = 1'b0;
	logic arst_n;

	pst_in_if  src_bytes ();
	pst_out_if tok_out ();

	packet_script_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(src_bytes),
		.tokens(tok_out)
	);

	token_t      pending_tokens[$];
	token_t      batch[$];
	logic [7:0]  script[$];
	lex_mode_t   mode;
	int unsigned pos;
	int unsigned tstart;
	bit          sunk;
	bit          gaps_on = 1'b1;
	int          fails = 0;
	int          items_sent = 0;
	int          tokens_seen = 0;
	int          cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("tb NOT OK");
			$finish;
		end
	end

	function automatic bit is_num_ch(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_alpha_ch(logic [7:0] c);
		return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
	endfunction

	function automatic bit is_hex_ch(logic [7:0] c);
		return is_num_ch(c) || (c >= CH_LOW_A && c <= CH_LOW_F) || (c >= CH_UP_A && c <= CH_UP_F);
	endfunction

	function automatic bit is_word_ch(logic [7:0] c);
		return is_alpha_ch(c) || is_num_ch(c) || c == CH_UNDER;
	endfunction

	function automatic bit is_blank_ch(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic logic [KIND_W-1:0] symbol_of(logic [7:0] c);
		case (c)
			CH_EQUAL:  return K_EQUAL;
			CH_LPAREN: return K_LPAREN;
			CH_RPAREN: return K_RPAREN;
			CH_COMMA:  return K_COMMA;
			CH_SLASH:  return K_SLASH;
			CH_COLON:  return K_COLON;
			default:   return K_IDENT;
		endcase
	endfunction

	function automatic void reset_lexer();
		mode = M_IDLE;
		pos = 0;
		tstart = 0;
		sunk = 1'b0;
	endfunction

	function automatic void add_token(logic [KIND_W-1:0] kind, logic [ERR_W-1:0] err,
		int unsigned start, int unsigned len, logic [7:0] bad);
		token_t t;
		if (batch.size() < MAX_RES) begin
			t.body.token_kind = kind;
			t.body.error_kind = err;
			t.body.start_pos = start[15:0];
			t.body.token_len = len[15:0];
			t.body.bad_char = bad;
			t.last = 1'b0;
			batch.push_back(t);
		end
	endfunction

	function automatic void flag_error(logic [ERR_W-1:0] err, int unsigned at, logic [7:0] bad);
		add_token(K_EOF, err, at, 0, bad);
		sunk = 1'b1;
		mode = M_IDLE;
	endfunction

	function automatic void finish_token(int unsigned endpos);
		int unsigned len;
		len = endpos - tstart;
		case (mode)
			M_IDENT:             add_token(K_IDENT, E_NONE, tstart, len, 8'h00);
			M_ZERO, M_DEC, M_HEX: add_token(K_INT, E_NONE, tstart, len, 8'h00);
			M_HEX0:              flag_error(E_HEX, tstart, 8'h00);
			M_MINUS:             flag_error(E_CHAR, tstart, CH_MINUS);
			M_STR, M_ESC:        flag_error(E_UNTERM, tstart, 8'h00);
			default: ;
		endcase
		mode = M_IDLE;
	endfunction

	function automatic void open_token(logic [7:0] c, int unsigned p);
		logic [KIND_W-1:0] sk;
		tstart = p;
		sk = symbol_of(c);
		if (is_blank_ch(c))
			return;
		if (c == CH_MINUS)
			mode = M_MINUS;
		else if (c == CH_QUOTE)
			mode = M_STR;
		else if (c == CH_ZERO)
			mode = M_ZERO;
		else if (is_num_ch(c))
			mode = M_DEC;
		else if (is_alpha_ch(c) || c == CH_UNDER)
			mode = M_IDENT;
		else if (sk != K_IDENT)
			add_token(sk, E_NONE, p, 1, 8'h00);
		else
			flag_error(E_CHAR, p, c);
	endfunction

	function automatic void lex_byte(logic [7:0] c);
		int unsigned p;
		p = pos;
		if (p >= 32'(POS_MAX)) begin
			flag_error(E_LONG, p, 8'h00);
			return;
		end
		case (mode)
			M_IDENT: begin
				if (!is_word_ch(c)) begin
					finish_token(p);
					open_token(c, p);
				end
			end
			M_ZERO: begin
				if (c == CH_LOW_X || c == CH_UP_X)
					mode = M_HEX0;
				else if (is_num_ch(c))
					mode = M_DEC;
				else begin
					finish_token(p);
					open_token(c, p);
				end
			end
			M_DEC: begin
				if (!is_num_ch(c)) begin
					finish_token(p);
					open_token(c, p);
				end
			end
			M_HEX0: begin
				if (is_hex_ch(c))
					mode = M_HEX;
				else
					flag_error(E_HEX, tstart, 8'h00);
			end
			M_HEX: begin
				if (!is_hex_ch(c)) begin
					finish_token(p);
					open_token(c, p);
				end
			end
			M_MINUS: begin
				if (c == CH_ZERO)
					mode = M_ZERO;
				else if (is_num_ch(c))
					mode = M_DEC;
				else
					flag_error(E_CHAR, tstart, CH_MINUS);
			end
			M_STR: begin
				if (c == CH_QUOTE) begin
					add_token(K_STRING, E_NONE, tstart, p + 1 - tstart, 8'h00);
					mode = M_IDLE;
				end else if (c == CH_BSLASH) begin
					mode = M_ESC;
				end
			end
			M_ESC: mode = M_STR;
			default: begin
				mode = M_IDLE;
				open_token(c, p);
			end
		endcase
		pos = p + 1;
	endfunction

	function automatic void tokenize_item(logic [7:0] c, logic eos, logic nc);
		batch.delete();
		if (!nc && !sunk)
			lex_byte(c);
		if (eos) begin
			if (!sunk) begin
				finish_token(pos);
				if (!sunk)
					add_token(K_EOF, E_NONE, pos, 0, 8'h00);
			end
			reset_lexer();
		end
		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		foreach (batch[i])
			pending_tokens.push_back(batch[i]);
	endfunction

	task automatic send_item(logic [7:0] c, logic eos, logic nc);
		int gap;
		gap = gaps_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			src_bytes.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_bytes.valid <= 1'b1;
		src_bytes.char_in <= c;
		src_bytes.end_of_source <= eos;
		src_bytes.no_char <= nc;
		do
			@(posedge clk);
		while (!src_bytes.ready);
		tokenize_item(c, eos, nc);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], i == s.len() - 1, 1'b0);
	endtask

	task automatic wait_drained();
		src_bytes.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_tokens.size() != 0);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		token_t t;
		if (arst_n && tok_out.valid && tok_out.ready) begin
			tokens_seen++;
			if (pending_tokens.size() == 0) begin
				fails++;
				$display("%0t: unexpected beat, expected none, got kind %0d err %0d pos %0d",
					$time, tok_out.token_kind, tok_out.error_kind, tok_out.start_pos);
			end else begin
				t = pending_tokens.pop_front();
				check_field("token_kind", t.body.token_kind, tok_out.token_kind);
				check_field("error_kind", t.body.error_kind, tok_out.error_kind);
				check_field("start_pos", t.body.start_pos, tok_out.start_pos);
				check_field("token_len", t.body.token_len, tok_out.token_len);
				check_field("bad_char", t.body.bad_char, tok_out.bad_char);
				check_field("last_of_run", t.last, tok_out.last_of_run);
			end
		end
	end

	initial begin
		int gap;
		forever begin
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				tok_out.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tok_out.ready <= 1'b1;
			do
				@(posedge clk);
			while (!tok_out.valid);
		end
	end

	function automatic logic [7:0] pick(string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic void add_random_token();
		int n;
		case ($urandom_range(0, 5))
			0: begin
				script.push_back(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
				n = $urandom_range(0, 5);
				repeat (n) script.push_back(pick("abcdefxyzQRSTU_0123456789"));
			end
			1: begin
				if ($urandom_range(0, 2) == 0)
					script.push_back(CH_MINUS);
				n = $urandom_range(1, 4);
				repeat (n) script.push_back(pick("0123456789"));
			end
			2: begin
				if ($urandom_range(0, 2) == 0)
					script.push_back(CH_MINUS);
				script.push_back(CH_ZERO);
				script.push_back($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
				n = $urandom_range(1, 3);
				repeat (n) script.push_back(pick("0123456789abcdefABCDEF"));
			end
			3: begin
				script.push_back(CH_QUOTE);
				n = $urandom_range(0, 4);
				repeat (n) begin
					if ($urandom_range(0, 3) == 0) begin
						script.push_back(CH_BSLASH);
						script.push_back(8'($urandom_range(0, 255)));
					end else begin
						script.push_back(pick("abc XYZ 019 =(),/:_-"));
					end
				end
				script.push_back(CH_QUOTE);
			end
			default: script.push_back(pick("=(),/:"));
		endcase
	endfunction

	function automatic void build_script();
		int n;
		int sep;
		script.delete();
		n = $urandom_range(0, 4);
		repeat (n) begin
			add_random_token();
			sep = $urandom_range(0, 2);
			repeat (sep) begin
				case ($urandom_range(0, 3))
					0: script.push_back(CH_SPACE);
					1: script.push_back(CH_TAB);
					2: script.push_back(CH_LF);
					default: script.push_back(CH_CR);
				endcase
			end
		end
		if ($urandom_range(0, 4) == 0)
			script.insert($urandom_range(0, script.size()), 8'($urandom_range(0, 255)));
		if (script.size() > 1 && $urandom_range(0, 9) == 0)
			while (script.size() > $urandom_range(1, script.size() - 1))
				void'(script.pop_back());
	endfunction

	task automatic send_script();
		bit split_end;
		split_end = script.size() == 0 || $urandom_range(0, 3) == 0;
		foreach (script[i]) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			send_item(script[i], !split_end && i == script.size() - 1, 1'b0);
		end
		if (split_end)
			send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
	endtask

	task automatic test_token_kinds();
		send_text("f=(-7,\"\\\"\",0Xa)/:");
	endtask

	task automatic test_empty_items();
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
	endtask

	task automatic test_errors();
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_text("\"ab");
		send_text("0xg1");
		send_text("0x");
		send_text("-a");
	endtask

	task automatic test_drain_pause();
		send_text("ab=12");
		wait_drained();
		send_text("(x)");
	endtask

	task automatic test_random_scripts();
		int first;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			gaps_on = $urandom_range(0, 3) != 0;
			build_script();
			send_script();
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		reset_lexer();
		arst_n <= 1'b0;
		src_bytes.valid <= 1'b0;
		src_bytes.char_in <= 8'h00;
		src_bytes.end_of_source <= 1'b0;
		src_bytes.no_char <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_token_kinds();
		test_empty_items();
		test_errors();
		test_drain_pause();
		test_random_scripts();

		wait_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d items and checked %0d tokens over directed and random sources,",
			items_sent, tokens_seen);
		$display("covering every token kind, the scan errors and random stalls on both channels.");
		if (fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
